// ===== sv/assert_macros.svh =====
// assertion macros used by the checker in plet_checker.sv
// no dependencies; take in with include before any use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in one cycle, consequent in the next, muted while in reset
`define PLET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plet assertion failed");

// same shape but live during reset, for checks on reset behaviour itself
`define PLET_ASSERT_RESET(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("plet reset assertion failed");

`endif

// ===== sv/plet_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and the microcode rom of the pose error tracker
// no dependencies; used by the interfaces, the top level and the checker
package plet_pkg;

    // field widths
    localparam int POS_W      = 32;
    localparam int QUAT_W     = 16;
    localparam int PERR_W     = 32;
    localparam int OERR_W     = 16;

    // smoothing factor format, Q0.ALPHA_BITS with one extra bit for 1.0
    localparam int ALPHA_BITS = 16;
    localparam int ALPHA_W    = ALPHA_BITS + 1;
    localparam int ALPHA_RST  = ((2 ** ALPHA_BITS) + 2) / 5;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_ALPHA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORI_ALPHA = 2'd1;

    // datapath operations
    typedef logic [3:0] t_op;
    localparam t_op OP_NOP      = 4'd0;
    localparam t_op OP_IDLE     = 4'd1;
    localparam t_op OP_MUL_EMA  = 4'd2;
    localparam t_op OP_UPDATE   = 4'd3;
    localparam t_op OP_MUL_SQ   = 4'd4;
    localparam t_op OP_ACC      = 4'd5;
    localparam t_op OP_SQRT_GO  = 4'd6;
    localparam t_op OP_POS_SAVE = 4'd7;
    localparam t_op OP_OUT      = 4'd8;

    // sequencer jump conditions
    typedef logic [2:0] t_cond;
    localparam t_cond JMP_NEXT   = 3'd0;
    localparam t_cond JMP_ALWAYS = 3'd1;
    localparam t_cond JMP_NOREQ  = 3'd2;
    localparam t_cond JMP_BUSY   = 3'd3;
    localparam t_cond JMP_FULL   = 3'd4;

    // component selector: 0..2 position axes, 3..6 quaternion parts
    typedef logic [2:0] t_comp;
    localparam t_comp COMP_QUAT0   = 3'd3;
    localparam t_comp SQRT_SEL_POS = 3'd0;
    localparam t_comp SQRT_SEL_ORI = 3'd1;

    // square root iteration counts
    localparam int SQ_CNT_W = 6;
    localparam logic [SQ_CNT_W-1:0] SQRT_ITER_POS = 6'd32;
    localparam logic [SQ_CNT_W-1:0] SQRT_ITER_ORI = 6'd17;

    // program layout
    localparam int UC_ADDR_W = 6;
    typedef logic [UC_ADDR_W-1:0] t_uc_addr;
    localparam t_uc_addr UC_IDLE      = 6'd0;
    localparam t_uc_addr UC_POS_FIRST = 6'd1;
    localparam t_uc_addr UC_POS_LAST  = 6'd12;
    localparam t_uc_addr UC_POS_SQRT  = 6'd13;
    localparam t_uc_addr UC_POS_WAIT  = 6'd14;
    localparam t_uc_addr UC_POS_SAVE  = 6'd15;
    localparam t_uc_addr UC_ORI_FIRST = 6'd16;
    localparam t_uc_addr UC_ORI_LAST  = 6'd31;
    localparam t_uc_addr UC_ORI_SQRT  = 6'd32;
    localparam t_uc_addr UC_ORI_WAIT  = 6'd33;
    localparam t_uc_addr UC_OUT       = 6'd34;
    localparam t_uc_addr UC_LAST      = 6'd35;

    typedef struct packed {
        t_op      op;
        t_comp    comp;
        t_cond    cond;
        t_uc_addr target;
    } t_ucode;

    // four steps per vector component
    function automatic t_op comp_step_op(input logic [1:0] sel);
        t_op op;
        case (sel)
            2'd0:    op = OP_MUL_EMA;
            2'd1:    op = OP_UPDATE;
            2'd2:    op = OP_MUL_SQ;
            default: op = OP_ACC;
        endcase
        return op;
    endfunction

    function automatic t_ucode ucode_rom(input t_uc_addr addr);
        t_ucode   uc;
        t_uc_addr idx;
        uc  = '{op: OP_NOP, comp: '0, cond: JMP_NEXT, target: '0};
        idx = '0;
        case (addr) inside
            UC_IDLE: begin
                uc = '{op: OP_IDLE, comp: '0, cond: JMP_NOREQ, target: UC_IDLE};
            end
            [UC_POS_FIRST:UC_POS_LAST]: begin
                idx     = addr - UC_POS_FIRST;
                uc.op   = comp_step_op(idx[1:0]);
                uc.comp = t_comp'(idx[UC_ADDR_W-1:2]);
            end
            UC_POS_SQRT: begin
                uc.op   = OP_SQRT_GO;
                uc.comp = SQRT_SEL_POS;
            end
            UC_POS_WAIT: begin
                uc = '{op: OP_NOP, comp: '0, cond: JMP_BUSY, target: UC_POS_WAIT};
            end
            UC_POS_SAVE: begin
                uc.op = OP_POS_SAVE;
            end
            [UC_ORI_FIRST:UC_ORI_LAST]: begin
                idx     = addr - UC_ORI_FIRST;
                uc.op   = comp_step_op(idx[1:0]);
                uc.comp = t_comp'(idx[UC_ADDR_W-1:2]) + COMP_QUAT0;
            end
            UC_ORI_SQRT: begin
                uc.op   = OP_SQRT_GO;
                uc.comp = SQRT_SEL_ORI;
            end
            UC_ORI_WAIT: begin
                uc = '{op: OP_NOP, comp: '0, cond: JMP_BUSY, target: UC_ORI_WAIT};
            end
            UC_OUT: begin
                uc = '{op: OP_OUT, comp: '0, cond: JMP_FULL, target: UC_OUT};
            end
            UC_LAST: begin
                uc = '{op: OP_NOP, comp: '0, cond: JMP_ALWAYS, target: UC_IDLE};
            end
            default: begin
                uc = '{op: OP_NOP, comp: '0, cond: JMP_ALWAYS, target: UC_IDLE};
            end
        endcase
        return uc;
    endfunction

endpackage

// ===== sv/plet_ifs.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces: pose request, error result, config write
// depends on plet_pkg for field widths
interface plet_pose_if;
    logic                              valid;
    logic                              ready;
    logic signed [plet_pkg::POS_W-1:0]  pos_x;
    logic signed [plet_pkg::POS_W-1:0]  pos_y;
    logic signed [plet_pkg::POS_W-1:0]  pos_z;
    logic signed [plet_pkg::QUAT_W-1:0] quat_x;
    logic signed [plet_pkg::QUAT_W-1:0] quat_y;
    logic signed [plet_pkg::QUAT_W-1:0] quat_z;
    logic signed [plet_pkg::QUAT_W-1:0] quat_w;

    modport source (output valid, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w,
                    output ready);
endinterface

interface plet_err_if;
    logic                        valid;
    logic                        ready;
    logic [plet_pkg::PERR_W-1:0] pos_err;
    logic [plet_pkg::OERR_W-1:0] ori_err;

    modport source (output valid, pos_err, ori_err, input ready);
    modport sink   (input valid, pos_err, ori_err, output ready);
endinterface

interface plet_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [plet_pkg::CFG_IDX_W-1:0] addr;
    logic [plet_pkg::ALPHA_W-1:0]   data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// ===== sv/pose_lowpass_error_tracker.sv =====
`timescale 1ns / 1ps
// pose low-pass error tracker: microcoded datapath with shared multiplier and root unit
// depends on plet_pkg and the channel interfaces in plet_ifs
//
// Takes one pose request (Q16.16 position, Q2.14 quaternion), updates an exponential
// moving average of each vector with its own Q0.16 smoothing factor (values above 1.0
// act as 1.0, rounding is to nearest with ties upward), and returns the Euclidean
// distance of the sample from its new average for position and for orientation.
// Both averages start at zero; the factors reset to 0.2 (13107). The block handles one
// request at a time, from acceptance until the sequencer is back at its idle step; its
// work is done by one 33x33 multiplier used twice per vector component (7 components,
// 4 steps each) and a bit-serial square root (32 iterations for position, 17 for
// orientation). The result sits in an output register, so the next request is taken
// while it waits; if it has not been taken by the end of the next request, the
// sequencer holds on its output step. A position error beyond 32 bits reads as all
// ones, an orientation error beyond 16 bits as 65535. Config writes are ready outside reset.
module pose_lowpass_error_tracker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    plet_pose_if.sink      i_pose,
    plet_err_if.source     o_err,
    plet_cfg_if.sink       i_cfg
);

    localparam int PROD_W = 66;
    localparam int ACC_W  = 66;
    localparam int MUL_W  = 33;
    localparam int REM_W  = 34;

    localparam logic [plet_pkg::ALPHA_W-1:0] ALPHA_ONE =
        {1'b1, {plet_pkg::ALPHA_BITS{1'b0}}};
    localparam logic [plet_pkg::ALPHA_W-1:0] ALPHA_RESET =
        plet_pkg::ALPHA_W'(plet_pkg::ALPHA_RST);
    localparam logic signed [PROD_W-1:0] EMA_HALF =
        PROD_W'(1) << (plet_pkg::ALPHA_BITS - 1);

    // sequencer
    logic [plet_pkg::UC_ADDR_W-1:0] r_pc;
    logic [plet_pkg::UC_ADDR_W-1:0] n_pc;
    plet_pkg::t_ucode               uc;

    // configuration
    logic [plet_pkg::ALPHA_W-1:0] r_pos_alpha;
    logic [plet_pkg::ALPHA_W-1:0] r_ori_alpha;

    // captured sample and running averages
    logic signed [plet_pkg::POS_W-1:0]  r_pos      [3];
    logic signed [plet_pkg::QUAT_W-1:0] r_quat     [4];
    logic signed [plet_pkg::POS_W-1:0]  r_avg_pos  [3];
    logic signed [plet_pkg::QUAT_W-1:0] r_avg_quat [4];

    // arithmetic registers
    logic signed [PROD_W-1:0] r_prod;
    logic [plet_pkg::POS_W-1:0] r_diff;
    logic [ACC_W-1:0]         r_acc;
    logic [plet_pkg::PERR_W-1:0] r_perr;

    // square root unit
    logic [63:0]                   r_sq_rad;
    logic [REM_W-1:0]              r_sq_rem;
    logic [31:0]                   r_sq_root;
    logic [plet_pkg::SQ_CNT_W-1:0] r_sq_cnt;

    // output register
    logic                        r_out_valid;
    logic [plet_pkg::PERR_W-1:0] r_out_perr;
    logic [plet_pkg::OERR_W-1:0] r_out_oerr;

    // datapath wires
    logic                              in_acc;
    logic                              out_free;
    logic                              sq_busy;
    logic                              is_pos;
    logic [1:0]                        qsel;
    logic signed [plet_pkg::POS_W-1:0] s_sel;
    logic signed [plet_pkg::POS_W-1:0] avg_sel;
    logic [plet_pkg::ALPHA_W-1:0]      a_raw;
    logic [plet_pkg::ALPHA_W-1:0]      a_eff;
    logic signed [MUL_W-1:0]           ema_d;
    logic signed [MUL_W-1:0]           mul_a;
    logic signed [MUL_W-1:0]           mul_b;
    logic signed [PROD_W-1:0]          mul_p;
    logic signed [PROD_W-1:0]          ema_inc;
    logic signed [MUL_W-1:0]           ema_new;
    logic signed [MUL_W-1:0]           err_s;
    logic signed [MUL_W-1:0]           err_neg;
    logic [plet_pkg::POS_W-1:0]        err_abs;
    logic [REM_W+1:0]                  sq_rem_sh;
    logic [REM_W+1:0]                  sq_trial;
    logic [REM_W+1:0]                  sq_rem_sub;

    assign uc       = plet_pkg::ucode_rom(r_pc);
    assign in_acc   = i_pose.valid && i_pose.ready;
    assign out_free = !r_out_valid || o_err.ready;
    assign sq_busy  = (r_sq_cnt != '0);

    assign i_pose.ready = i_rst_n && (uc.op == plet_pkg::OP_IDLE);
    assign i_cfg.ready  = i_rst_n;

    assign o_err.valid   = r_out_valid;
    assign o_err.pos_err = r_out_perr;
    assign o_err.ori_err = r_out_oerr;

    // component select: position axes first, then quaternion parts
    assign is_pos = (uc.comp < plet_pkg::COMP_QUAT0);
    assign qsel   = 2'(uc.comp - plet_pkg::COMP_QUAT0);

    always_comb begin
        if (is_pos) begin
            s_sel   = r_pos[uc.comp[1:0]];
            avg_sel = r_avg_pos[uc.comp[1:0]];
            a_raw   = r_pos_alpha;
        end else begin
            s_sel   = plet_pkg::POS_W'(r_quat[qsel]);
            avg_sel = plet_pkg::POS_W'(r_avg_quat[qsel]);
            a_raw   = r_ori_alpha;
        end
    end

    // a factor above one acts as exactly one
    assign a_eff = (a_raw > ALPHA_ONE) ? ALPHA_ONE : a_raw;
    assign ema_d = MUL_W'(s_sel) - MUL_W'(avg_sel);

    // shared multiplier: alpha times (sample - avg), or the error squared
    always_comb begin
        if (uc.op == plet_pkg::OP_MUL_SQ) begin
            mul_a = {1'b0, r_diff};
            mul_b = {1'b0, r_diff};
        end else begin
            mul_a = MUL_W'(a_eff);
            mul_b = ema_d;
        end
    end
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // new average = avg + round(alpha * (sample - avg)), result stays in range
    assign ema_inc = (r_prod + EMA_HALF) >>> plet_pkg::ALPHA_BITS;
    assign ema_new = MUL_W'(avg_sel) + ema_inc[MUL_W-1:0];
    assign err_s   = MUL_W'(s_sel) - ema_new;
    assign err_neg = -err_s;
    assign err_abs = err_s[MUL_W-1] ? err_neg[plet_pkg::POS_W-1:0]
                                    : err_s[plet_pkg::POS_W-1:0];

    // one restoring root step: bring down two radicand bits, try 4*root+1
    assign sq_rem_sh  = {r_sq_rem, r_sq_rad[63:62]};
    assign sq_trial   = {2'b00, r_sq_root, 2'b01};
    assign sq_rem_sub = sq_rem_sh - sq_trial;

    // next step of the program
    always_comb begin
        case (uc.cond)
            plet_pkg::JMP_NEXT:   n_pc = r_pc + 1'b1;
            plet_pkg::JMP_ALWAYS: n_pc = uc.target;
            plet_pkg::JMP_NOREQ:  n_pc = in_acc ? r_pc + 1'b1 : uc.target;
            plet_pkg::JMP_BUSY:   n_pc = sq_busy ? uc.target : r_pc + 1'b1;
            plet_pkg::JMP_FULL:   n_pc = out_free ? r_pc + 1'b1 : uc.target;
            default:              n_pc = uc.target;
        endcase
    end

    // control state, averages and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= plet_pkg::UC_IDLE;
            r_pos_alpha <= ALPHA_RESET;
            r_ori_alpha <= ALPHA_RESET;
            r_sq_cnt    <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_avg_pos[k] <= '0;
            end
            for (int k = 0; k < 4; k++) begin
                r_avg_quat[k] <= '0;
            end
        end else begin
            r_pc <= n_pc;

            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.addr)
                    plet_pkg::CFG_POS_ALPHA: r_pos_alpha <= i_cfg.data;
                    plet_pkg::CFG_ORI_ALPHA: r_ori_alpha <= i_cfg.data;
                    default: ;
                endcase
            end

            if (uc.op == plet_pkg::OP_UPDATE) begin
                if (is_pos) begin
                    r_avg_pos[uc.comp[1:0]] <= ema_new[plet_pkg::POS_W-1:0];
                end else begin
                    r_avg_quat[qsel] <= ema_new[plet_pkg::QUAT_W-1:0];
                end
            end

            // root unit counts down its iterations
            if (uc.op == plet_pkg::OP_SQRT_GO) begin
                r_sq_cnt <= (uc.comp == plet_pkg::SQRT_SEL_POS) ? plet_pkg::SQRT_ITER_POS
                                                                 : plet_pkg::SQRT_ITER_ORI;
            end else if (sq_busy) begin
                r_sq_cnt <= r_sq_cnt - 1'b1;
            end

            // output register: load on the output step, drop when taken
            if ((uc.op == plet_pkg::OP_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_err.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pos[0]  <= i_pose.pos_x;
            r_pos[1]  <= i_pose.pos_y;
            r_pos[2]  <= i_pose.pos_z;
            r_quat[0] <= i_pose.quat_x;
            r_quat[1] <= i_pose.quat_y;
            r_quat[2] <= i_pose.quat_z;
            r_quat[3] <= i_pose.quat_w;
        end

        case (uc.op)
            plet_pkg::OP_IDLE:     r_acc  <= '0;
            plet_pkg::OP_MUL_EMA:  r_prod <= mul_p;
            plet_pkg::OP_UPDATE:   r_diff <= err_abs;
            plet_pkg::OP_MUL_SQ:   r_prod <= mul_p;
            plet_pkg::OP_ACC:      r_acc  <= r_acc + {2'b00, r_prod[63:0]};
            plet_pkg::OP_POS_SAVE: begin
                // a sum of squares of 2^64 or more cannot root to 32 bits
                r_perr <= (r_acc[ACC_W-1:64] != '0) ? '1 : r_sq_root;
                r_acc  <= '0;
            end
            default: ;
        endcase

        if (uc.op == plet_pkg::OP_SQRT_GO) begin
            // orientation sum is at most 34 bits, left-justified for 17 steps
            r_sq_rad  <= (uc.comp == plet_pkg::SQRT_SEL_POS) ? r_acc[63:0]
                                                             : {r_acc[33:0], 30'd0};
            r_sq_rem  <= '0;
            r_sq_root <= '0;
        end else if (sq_busy) begin
            r_sq_rad <= {r_sq_rad[61:0], 2'b00};
            if (sq_rem_sh >= sq_trial) begin
                r_sq_rem  <= sq_rem_sub[REM_W-1:0];
                r_sq_root <= {r_sq_root[30:0], 1'b1};
            end else begin
                r_sq_rem  <= sq_rem_sh[REM_W-1:0];
                r_sq_root <= {r_sq_root[30:0], 1'b0};
            end
        end

        if ((uc.op == plet_pkg::OP_OUT) && out_free) begin
            r_out_perr <= r_perr;
            r_out_oerr <= (r_sq_root[31:16] != '0) ? '1 : r_sq_root[15:0];
        end
    end

endmodule

// ===== sv/plet_checker.sv =====
`timescale 1ns / 1ps
// port-level checker for the pose error tracker, bound to the top level
// depends on plet_pkg and assert_macros.svh
`include "assert_macros.svh"

module plet_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [plet_pkg::PERR_W-1:0] i_out_perr,
    input logic [plet_pkg::OERR_W-1:0] i_out_oerr
);

    logic                                         out_stall;
    logic [plet_pkg::PERR_W+plet_pkg::OERR_W-1:0] out_payload;

    assign out_stall   = i_out_valid && !i_out_ready;
    assign out_payload = {i_out_perr, i_out_oerr};

    // a stalled result keeps its valid
    `PLET_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid)

    // a stalled result keeps its payload
    `PLET_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, out_stall, $stable(out_payload))

    // reset empties the output register
    `PLET_ASSERT_RESET(a_rst_clear, i_clk, !i_rst_n, !i_out_valid)

    // only one request is in the sequencer at a time
    `PLET_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

endmodule

bind pose_lowpass_error_tracker plet_checker u_plet_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pose.valid),
    .i_in_ready  (i_pose.ready),
    .i_out_valid (o_err.valid),
    .i_out_ready (o_err.ready),
    .i_out_perr  (o_err.pos_err),
    .i_out_oerr  (o_err.ori_err)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// testbench for pose_lowpass_error_tracker: directed and random pose requests
// checked against a predictor of both moving averages and error norms
// depends on plet_pkg, the channel interfaces in plet_ifs and the block itself
module tb;

    // unpacked pose request as the predictor sees it
    typedef struct {
        logic signed [plet_pkg::POS_W-1:0]  pos[3];
        logic signed [plet_pkg::QUAT_W-1:0] quat[4];
    } t_pose_req;

    typedef struct packed {
        logic [plet_pkg::PERR_W-1:0] position;
        logic [plet_pkg::OERR_W-1:0] orientation;
    } t_pose_err;

    // the two register indexes the block ignores
    localparam logic [plet_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [plet_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam longint ALPHA_ONE   = longint'(1) << plet_pkg::ALPHA_BITS;
    localparam logic [plet_pkg::ALPHA_W-1:0] ALPHA_MAX = '1;
    localparam int     POS_STEP    = 1 << 18;
    localparam int     QUAT_STEP   = 512;
    localparam int     QUAT_LIMIT  = 16384;
    localparam int     CHUNK_ITEMS = 140;

    logic i_clk;
    logic i_rst_n;

    plet_pose_if pose_if ();
    plet_err_if  err_if ();
    plet_cfg_if  cfg_if ();

    pose_lowpass_error_tracker uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pose  (pose_if),
        .o_err   (err_if),
        .i_cfg   (cfg_if)
    );

    // predictor state: smoothing factors and both running averages
    logic [plet_pkg::ALPHA_W-1:0] pos_alpha = plet_pkg::ALPHA_W'(plet_pkg::ALPHA_RST);
    logic [plet_pkg::ALPHA_W-1:0] ori_alpha = plet_pkg::ALPHA_W'(plet_pkg::ALPHA_RST);
    longint avg_pos[3]  = '{0, 0, 0};
    longint avg_quat[4] = '{0, 0, 0, 0};

    t_pose_err expected_errors[$];
    t_pose_req walk;

    int send_idle_pct;
    int recv_idle_pct;
    int requests_sent;
    int results_checked;
    int settings_applied;
    int mismatch_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #(20_000_000);
        $display("%0t: timeout with %0d results outstanding", $time, expected_errors.size());
        $display("DONE: errors detected");
        $finish;
    end

    // ---------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------

    // one smoothing step, rounded to nearest with ties toward plus infinity;
    // factors above one behave as exactly one
    function automatic longint smooth(input longint sample, input longint avg,
                                      input logic [plet_pkg::ALPHA_W-1:0] alpha);
        longint a;
        longint acc;
        a   = (alpha > ALPHA_ONE) ? ALPHA_ONE : longint'(alpha);
        acc = a * sample + (ALPHA_ONE - a) * avg + (ALPHA_ONE >>> 1);
        return acc >>> plet_pkg::ALPHA_BITS;
    endfunction

    // floor square root, digit by digit
    function automatic logic [32:0] floor_sqrt(input logic [65:0] v);
        logic [65:0] rem;
        logic [65:0] root;
        logic [65:0] bitv;
        rem  = v;
        root = '0;
        bitv = 66'd1 << 64;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root[32:0];
    endfunction

    // advances both averages by one request and returns the distances from them
    function automatic t_pose_err pose_error_of(input t_pose_req p);
        t_pose_err   res;
        longint      s;
        longint      n;
        logic [65:0] dd;
        logic [65:0] sum;
        logic [32:0] root;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            s           = longint'(p.pos[i]);
            n           = smooth(s, avg_pos[i], pos_alpha);
            avg_pos[i]  = n;
            dd          = (s >= n) ? 66'(s - n) : 66'(n - s);
            sum         = sum + dd * dd;
        end
        root = floor_sqrt(sum);
        // a sum of squares at or beyond 2^64 saturates the position error
        res.position = (sum >= (66'd1 << 64)) ? '1 : root[plet_pkg::PERR_W-1:0];

        sum = '0;
        for (int i = 0; i < 4; i++) begin
            s           = longint'(p.quat[i]);
            n           = smooth(s, avg_quat[i], ori_alpha);
            avg_quat[i] = n;
            dd          = (s >= n) ? 66'(s - n) : 66'(n - s);
            sum         = sum + dd * dd;
        end
        root = floor_sqrt(sum);
        res.orientation = (root > 33'd65535) ? '1 : root[plet_pkg::OERR_W-1:0];
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------------

    function automatic t_pose_req pose_of(
        input logic signed [plet_pkg::POS_W-1:0] px,
        input logic signed [plet_pkg::POS_W-1:0] py,
        input logic signed [plet_pkg::POS_W-1:0] pz,
        input logic signed [plet_pkg::QUAT_W-1:0] qx,
        input logic signed [plet_pkg::QUAT_W-1:0] qy,
        input logic signed [plet_pkg::QUAT_W-1:0] qz,
        input logic signed [plet_pkg::QUAT_W-1:0] qw);
        t_pose_req p;
        p.pos  = '{px, py, pz};
        p.quat = '{qx, qy, qz, qw};
        return p;
    endfunction

    // sends one request; valid is left high so back-to-back requests need no toggle,
    // and the expectation is queued at the accepting edge
    task automatic send_pose(input t_pose_req p);
        while ($urandom_range(99) < send_idle_pct) begin
            pose_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pose_if.valid  <= 1'b1;
        pose_if.pos_x  <= p.pos[0];
        pose_if.pos_y  <= p.pos[1];
        pose_if.pos_z  <= p.pos[2];
        pose_if.quat_x <= p.quat[0];
        pose_if.quat_y <= p.quat[1];
        pose_if.quat_z <= p.quat[2];
        pose_if.quat_w <= p.quat[3];
        do @(posedge i_clk); while (!pose_if.ready);
        expected_errors.insert(expected_errors.size(), pose_error_of(p));
        requests_sent++;
    endtask

    // stop requesting and let every outstanding result come back
    task automatic wait_for_results();
        pose_if.valid <= 1'b0;
        while (expected_errors.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [plet_pkg::CFG_IDX_W-1:0] idx,
                             input logic [plet_pkg::ALPHA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            plet_pkg::CFG_POS_ALPHA: pos_alpha = value;
            plet_pkg::CFG_ORI_ALPHA: ori_alpha = value;
            default: ;
        endcase
    endtask

    // registers only change with the block idle
    task automatic set_alphas(input logic [plet_pkg::ALPHA_W-1:0] pa,
                              input logic [plet_pkg::ALPHA_W-1:0] oa);
        wait_for_results();
        write_cfg(plet_pkg::CFG_POS_ALPHA, pa);
        write_cfg(plet_pkg::CFG_ORI_ALPHA, oa);
        cfg_if.valid <= 1'b0;
        settings_applied++;
    endtask

    // ---------------------------------------------------------------------
    // result side: random stalls plus the in-order check
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pose_err want;
        if (i_rst_n && err_if.valid && err_if.ready) begin
            if (expected_errors.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, got %0d / %0d",
                         $time, err_if.pos_err, err_if.ori_err);
                mismatch_count++;
            end else begin
                want = expected_errors.pop_front();
                results_checked++;
                if (err_if.pos_err !== want.position) begin
                    $display("%0t: position error mismatch, expected %0d, got %0d",
                             $time, want.position, err_if.pos_err);
                    mismatch_count++;
                end
                if (err_if.ori_err !== want.orientation) begin
                    $display("%0t: orientation error mismatch, expected %0d, got %0d",
                             $time, want.orientation, err_if.ori_err);
                    mismatch_count++;
                end
            end
        end
        err_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------

    // smoothing factor biased toward the corners, over the full register width
    function automatic logic [plet_pkg::ALPHA_W-1:0] pick_alpha();
        case ($urandom_range(7))
            0:       return '0;
            1:       return plet_pkg::ALPHA_W'(ALPHA_ONE);
            2:       return plet_pkg::ALPHA_W'($urandom_range(ALPHA_ONE + 1, ALPHA_MAX));
            3:       return plet_pkg::ALPHA_W'(1);
            default: return plet_pkg::ALPHA_W'($urandom_range(0, ALPHA_ONE));
        endcase
    endfunction

    // mostly a slowly moving pose so the averages track something plausible,
    // with some jumps, holds and unrelated full-range noise mixed in
    function automatic t_pose_req wander_pose();
        t_pose_req p;
        int        pick;
        int        q;
        pick = $urandom_range(99);
        if (pick < 15) begin
            foreach (p.pos[i])
                p.pos[i] = $urandom();
            foreach (p.quat[i])
                p.quat[i] = (pick < 8) ? plet_pkg::QUAT_W'($urandom())
                          : plet_pkg::QUAT_W'($urandom_range(0, 2 * QUAT_LIMIT) - QUAT_LIMIT);
            return p;
        end
        if (pick < 20)
            return walk;
        if (pick < 23) begin
            foreach (walk.pos[i])
                walk.pos[i] = $urandom();
        end
        foreach (walk.pos[i])
            walk.pos[i] = walk.pos[i] + (int'($urandom_range(0, 2 * POS_STEP)) - POS_STEP);
        foreach (walk.quat[i]) begin
            q = int'(walk.quat[i]) + int'($urandom_range(0, 2 * QUAT_STEP)) - QUAT_STEP;
            if (q > QUAT_LIMIT)
                q = QUAT_LIMIT;
            if (q < -QUAT_LIMIT)
                q = -QUAT_LIMIT;
            walk.quat[i] = plet_pkg::QUAT_W'(q);
        end
        return walk;
    endfunction

    // reset values of both factors, field extremes and out-of-range quaternion parts
    task automatic test_reset_defaults();
        send_pose(pose_of(0, 0, 0, 0, 0, 0, 0));
        send_pose(pose_of(32'h7fffffff, 32'h80000000, 32'h00010000,
                          16'sd16384, -16'sd16384, 0, 0));
        send_pose(pose_of(32'h80000000, 32'h7fffffff, -1,
                          -16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384));
        // any 16-bit pattern counts as a two's complement quaternion part
        send_pose(pose_of(32'h12345678, -32'sd5, 32'h00008000,
                          16'sh7fff, 16'sh8000, 16'sd1, -16'sd1));
    endtask

    // factor of zero freezes an average, one or more makes it follow the sample
    task automatic test_alpha_extremes();
        set_alphas('0, plet_pkg::ALPHA_W'(ALPHA_ONE));
        send_pose(pose_of(32'h00030000, -32'sh00020000, 32'h7fffffff, 100, -200, 300, 16384));
        send_pose(pose_of(32'h80000000, 1, 0, 16'sh8000, 16'sh7fff, 0, -1));
        // values above one behave as one, including the largest register value
        set_alphas(plet_pkg::ALPHA_W'(ALPHA_ONE + 1), ALPHA_MAX);
        send_pose(pose_of(-32'sh00050000, 32'h00001234, 32'h80000000, 5, 6, 7, 8));
        send_pose(pose_of(32'h0f0f0f0f, 32'hf0f0f0f0, 32'h55555555, -9, 10, -11, 12));
        // writes to the unused indexes must leave both factors alone
        wait_for_results();
        write_cfg(CFG_SPARE_A, ALPHA_MAX);
        write_cfg(CFG_SPARE_B, '0);
        cfg_if.valid <= 1'b0;
        send_pose(pose_of(32'h00010000, 32'h00020000, 32'h00030000, 1000, 2000, 3000, 4000));
        set_alphas(plet_pkg::ALPHA_W'(1), plet_pkg::ALPHA_W'(1));
        send_pose(pose_of(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16384, 16384, 16384, 16384));
    endtask

    // pull both averages to the negative corner, then jump to the positive one
    task automatic test_saturation();
        set_alphas(plet_pkg::ALPHA_W'(ALPHA_ONE), plet_pkg::ALPHA_W'(ALPHA_ONE));
        send_pose(pose_of(32'h80000000, 32'h80000000, 32'h80000000,
                          16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
        set_alphas('0, '0);
        // one axis at full span: root is exactly 2^32 - 1, no saturation
        send_pose(pose_of(32'h7fffffff, 32'h80000000, 32'h80000000,
                          16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000));
        // sum of squares overflows 64 bits, orientation root passes 16 bits
        send_pose(pose_of(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff));
        send_pose(pose_of(32'h7fffffff, 32'h7fffffff, 32'h80000000,
                          16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000));
    endtask

    // half-way factor puts the average on exact ties, which must round upward
    task automatic test_rounding();
        set_alphas(plet_pkg::ALPHA_W'(ALPHA_ONE), plet_pkg::ALPHA_W'(ALPHA_ONE));
        send_pose(pose_of(0, 0, 0, 0, 0, 0, 0));
        set_alphas(plet_pkg::ALPHA_W'(ALPHA_ONE / 2), plet_pkg::ALPHA_W'(ALPHA_ONE / 2));
        send_pose(pose_of(1, -1, 3, 1, -1, 3, -3));
        send_pose(pose_of(0, 0, 0, 0, 0, 0, 0));
        send_pose(pose_of(-2, -2, 2, -2, -2, 2, 2));
    endtask

    // random requests in chunks, each chunk under a fresh pair of factors
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int chunks);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int c = 0; c < chunks; c++) begin
            set_alphas(pick_alpha(), pick_alpha());
            if (c == 1) begin
                write_cfg(($urandom_range(1)) ? CFG_SPARE_A : CFG_SPARE_B,
                          plet_pkg::ALPHA_W'($urandom()));
                cfg_if.valid <= 1'b0;
            end
            for (int k = 0; k < CHUNK_ITEMS; k++) begin
                send_pose(wander_pose());
                // occasionally let the pipeline run dry mid-stream
                if ($urandom_range(99) == 0)
                    wait_for_results();
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        pose_if.valid  = 1'b0;
        pose_if.pos_x  = '0;
        pose_if.pos_y  = '0;
        pose_if.pos_z  = '0;
        pose_if.quat_x = '0;
        pose_if.quat_y = '0;
        pose_if.quat_z = '0;
        pose_if.quat_w = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.addr    = '0;
        cfg_if.data    = '0;
        send_idle_pct  = 32;
        recv_idle_pct  = 45;
        walk           = pose_of(0, 0, 0, 0, 0, 0, 16384);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_alpha_extremes();
        test_saturation();
        test_rounding();
        test_random_traffic(32, 45, 4);
        test_random_traffic(45, 32, 4);
        test_random_traffic(0, 0, 4);

        // drain, then give any stray result time to show up
        wait_for_results();
        repeat (200) @(posedge i_clk);
        if (expected_errors.size() != 0) begin
            $display("%0t: results missing, expected %0d more, got none",
                     $time, expected_errors.size());
            mismatch_count++;
        end

        $display("sent %0d pose requests, checked %0d error results", requests_sent,
                 results_checked);
        $display("across %0d smoothing factor settings and three idling patterns",
                 settings_applied);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/plet_pkg.sv
sv/plet_ifs.sv
sv/pose_lowpass_error_tracker.sv
sv/plet_checker.sv
dv/tb.sv
